>>> hw/rtl/sliding_window_median_max_unit_macros.svh
// Assertion helpers for the sliding window median unit.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SLIDING_WINDOW_MEDIAN_MAX_UNIT_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_MAX_UNIT_MACROS_SVH

// Same-cycle implication.
`define SWM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SWM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/swm_pkg.sv
package swm_pkg;

    // Fixed field widths of the request and result channels.
    localparam int SAMPLE_W = 10;
    localparam int WIN_W    = 9;
    localparam int OUT_W    = 10;

    // Window size after reset.
    localparam logic [WIN_W-1:0] WINDOW_SIZE_RESET = 9'd3;

    // One incoming request.
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
    } sample_item_t;

    // One outgoing result.
    typedef struct packed {
        logic [OUT_W-1:0] median;
        logic             median_valid;
        logic [OUT_W-1:0] running_max;
    } result_item_t;

endpackage

>>> hw/rtl/swm_stream_if.sv
// Valid/ready channel carrying one payload per request.
interface swm_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/swm_ram.sv
// Simple dual-port synchronous RAM with a registered read. A read of the
// address being written in the same cycle returns the new data.
module swm_ram #(
    parameter int DEPTH = 1024,
    parameter int DATA_W = 9,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with write-to-read forwarding.
    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/sliding_window_median_max_unit.sv
// Sliding window lower median with a running maximum. Each sample request
// gives one result. Requests are handled one at a time. A request walks the
// count tree memory, which is visited once per tree level by the removal
// walk, the insertion walk and the median search. Only a request on a full
// window has a removal walk, and only one that leaves the window full has a
// median search. A request also waits while the previous result has not
// been taken. After reset, and after every write of window_size, the count
// tree is cleared one entry a cycle, and no request is taken until every
// entry is cleared. A write of window_size restarts the window and keeps
// the running maximum.
module sliding_window_median_max_unit #(
    parameter int VALUE_BITS = 10,
    parameter int MAX_WINDOW = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [swm_pkg::WIN_W-1:0]  cfg_wdata,
    swm_stream_if.sink                 samples,
    swm_stream_if.source               results
);

    localparam int TREE_SIZE = 1 << VALUE_BITS;
    localparam int WIN_LIMIT = (1 << swm_pkg::WIN_W) - 1;
    localparam int KMAX      = (MAX_WINDOW < WIN_LIMIT) ? MAX_WINDOW : WIN_LIMIT;
    localparam int CNT_W     = $clog2(KMAX + 1);
    localparam int PTR_W     = $clog2(MAX_WINDOW);
    localparam int IDX_W     = VALUE_BITS + 1;
    localparam int SUM_W     = VALUE_BITS + 2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RING,
        ST_DEL,
        ST_ADD,
        ST_SEL,
        ST_DONE
    } state_t;

    state_t                     state_reg, state_next;
    logic [swm_pkg::WIN_W-1:0]  window_size_reg, window_size_next;
    logic [PTR_W-1:0]           wp_reg, wp_next;
    logic [CNT_W-1:0]           fill_reg, fill_next;
    logic [swm_pkg::OUT_W-1:0]  best_reg, best_next;
    logic [VALUE_BITS-1:0]      clr_reg, clr_next;
    logic [VALUE_BITS-1:0]      sample_reg, sample_next;
    logic [CNT_W-1:0]           k_reg, k_next;
    logic [PTR_W-1:0]           slot_reg, slot_next;
    logic                       remove_reg, remove_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [IDX_W-1:0]           pos_reg, pos_next;
    logic [CNT_W-1:0]           rem_reg, rem_next;
    logic [IDX_W-1:0]           step_reg, step_next;
    logic [swm_pkg::OUT_W-1:0]  med_reg, med_next;
    logic                       valid_reg, valid_next;
    logic                       out_valid_reg, out_valid_next;
    swm_pkg::result_item_t      out_payload_reg, out_payload_next;

    logic                       tree_we;
    logic [VALUE_BITS-1:0]      tree_waddr;
    logic [CNT_W-1:0]           tree_wdata;
    logic [VALUE_BITS-1:0]      tree_raddr;
    logic [CNT_W-1:0]           tree_rdata;
    logic                       ring_we;
    logic [PTR_W-1:0]           ring_raddr;
    logic [VALUE_BITS-1:0]      ring_rdata;

    logic                       in_ready;
    logic                       in_accept;
    logic [CNT_W-1:0]           k_eff;
    logic [PTR_W-1:0]           wp_eff;
    logic [31:0]                wp_inc;
    logic [IDX_W-1:0]           walk_lsb;
    logic [SUM_W-1:0]           walk_nxt;
    logic [IDX_W-1:0]           start_idx;
    logic [IDX_W-1:0]           add_idx;
    logic [SUM_W-1:0]           sel_nxt;
    logic                       sel_take;
    logic [IDX_W-1:0]           sel_pos;
    logic [CNT_W-1:0]           sel_rem;
    logic [IDX_W-1:0]           sel_step;
    logic [IDX_W-1:0]           sel_clamped;

    // Count tree: index i of the tree lives at address i modulo the tree size.
    swm_ram #(
        .DEPTH  (TREE_SIZE),
        .DATA_W (CNT_W)
    ) u_tree_ram (
        .clk    (clk),
        .we     (tree_we),
        .waddr  (tree_waddr),
        .wdata  (tree_wdata),
        .raddr  (tree_raddr),
        .rdata  (tree_rdata)
    );

    // History ring of the samples in the window.
    swm_ram #(
        .DEPTH  (MAX_WINDOW),
        .DATA_W (VALUE_BITS)
    ) u_ring_ram (
        .clk    (clk),
        .we     (ring_we),
        .waddr  (slot_reg),
        .wdata  (sample_reg),
        .raddr  (ring_raddr),
        .rdata  (ring_rdata)
    );

    // Channel handshakes.
    assign in_ready        = (state_reg == ST_IDLE) && !cfg_we;
    assign in_accept       = samples.valid && in_ready;
    assign samples.ready   = in_ready;
    assign results.valid   = out_valid_reg;
    assign results.payload = out_payload_reg;

    // Effective window length, clamped to 1..MAX_WINDOW.
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            k_eff = CNT_W'(1);
        end
        else if (32'(window_size_reg) > 32'(MAX_WINDOW))
        begin
            k_eff = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            k_eff = CNT_W'(window_size_reg);
        end
    end

    // Ring slot for this request and the pointer that follows it.
    assign wp_eff = (32'(wp_reg) >= 32'(k_eff)) ? '0 : wp_reg;
    assign wp_inc = 32'(wp_eff) + 32'd1;

    // Fenwick walk: next index up the tree.
    assign walk_lsb = idx_reg & (~idx_reg + IDX_W'(1));
    assign walk_nxt = SUM_W'(idx_reg) + SUM_W'(walk_lsb);

    // Tree indices where the removal and insertion walks begin.
    assign start_idx = remove_reg ? (IDX_W'(ring_rdata) + IDX_W'(1))
                                  : (IDX_W'(sample_reg) + IDX_W'(1));
    assign add_idx   = IDX_W'(sample_reg) + IDX_W'(1);

    // One level of the median search.
    assign sel_nxt     = SUM_W'(pos_reg) + SUM_W'(step_reg);
    assign sel_take    = (sel_nxt <= SUM_W'(TREE_SIZE)) && (tree_rdata <= rem_reg);
    assign sel_pos     = sel_take ? IDX_W'(sel_nxt) : pos_reg;
    assign sel_rem     = sel_take ? (rem_reg - tree_rdata) : rem_reg;
    assign sel_step    = step_reg >> 1;
    assign sel_clamped = (sel_pos >= IDX_W'(TREE_SIZE)) ? IDX_W'(TREE_SIZE - 1) : sel_pos;

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        window_size_next = window_size_reg;
        wp_next          = wp_reg;
        fill_next        = fill_reg;
        best_next        = best_reg;
        clr_next         = clr_reg;
        sample_next      = sample_reg;
        k_next           = k_reg;
        slot_next        = slot_reg;
        remove_next      = remove_reg;
        idx_next         = idx_reg;
        pos_next         = pos_reg;
        rem_next         = rem_reg;
        step_next        = step_reg;
        med_next         = med_reg;
        valid_next       = valid_reg;
        out_valid_next   = out_valid_reg;
        out_payload_next = out_payload_reg;
        tree_we          = 1'b0;
        tree_waddr       = idx_reg[VALUE_BITS-1:0];
        tree_wdata       = '0;
        tree_raddr       = '0;
        ring_we          = 1'b0;
        ring_raddr       = wp_eff;

        // The result register empties when its request is taken.
        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Zero the count tree one entry a cycle.
                tree_we    = 1'b1;
                tree_waddr = clr_reg;
                tree_wdata = '0;
                clr_next   = clr_reg + VALUE_BITS'(1);
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                // Take a sample and advance the window bookkeeping.
                if (in_accept)
                begin
                    sample_next = VALUE_BITS'(samples.payload.sample);
                    k_next      = k_eff;
                    slot_next   = wp_eff;
                    remove_next = (fill_reg >= k_eff);
                    fill_next   = (fill_reg >= k_eff) ? k_eff : (fill_reg + CNT_W'(1));
                    wp_next     = (wp_inc >= 32'(k_eff)) ? '0 : PTR_W'(wp_inc);
                    state_next  = ST_RING;
                end
            end

            ST_RING:
            begin
                // The leaving sample is on the ring read port; replace it.
                ring_we    = 1'b1;
                tree_raddr = start_idx[VALUE_BITS-1:0];
                idx_next   = start_idx;
                state_next = remove_reg ? ST_DEL : ST_ADD;
            end

            ST_DEL,
            ST_ADD:
            begin
                // Update one tree level and fetch the next one.
                tree_we    = 1'b1;
                tree_wdata = (state_reg == ST_DEL) ? (tree_rdata - CNT_W'(1))
                                                   : (tree_rdata + CNT_W'(1));
                if (walk_nxt <= SUM_W'(TREE_SIZE))
                begin
                    idx_next   = IDX_W'(walk_nxt);
                    tree_raddr = walk_nxt[VALUE_BITS-1:0];
                end
                else if (state_reg == ST_DEL)
                begin
                    idx_next   = add_idx;
                    tree_raddr = add_idx[VALUE_BITS-1:0];
                    state_next = ST_ADD;
                end
                else if (fill_reg >= k_reg)
                begin
                    // Window full: search for rank (K - 1) / 2 from the root.
                    pos_next   = '0;
                    rem_next   = (k_reg - CNT_W'(1)) >> 1;
                    step_next  = IDX_W'(TREE_SIZE);
                    tree_raddr = '0;
                    state_next = ST_SEL;
                end
                else
                begin
                    med_next   = '0;
                    valid_next = 1'b0;
                    state_next = ST_DONE;
                end
            end

            ST_SEL:
            begin
                // Descend one level of the count tree.
                pos_next  = sel_pos;
                rem_next  = sel_rem;
                step_next = sel_step;
                if (sel_step != '0)
                begin
                    tree_raddr = VALUE_BITS'(sel_pos + sel_step);
                end
                else
                begin
                    med_next   = swm_pkg::OUT_W'(sel_clamped);
                    valid_next = 1'b1;
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // Load the result once the output register is free.
                if (!out_valid_reg || results.ready)
                begin
                    if (valid_reg && (med_reg > best_reg))
                    begin
                        best_next = med_reg;
                        out_payload_next.running_max = med_reg;
                    end
                    else
                    begin
                        out_payload_next.running_max = best_reg;
                    end
                    out_payload_next.median       = med_reg;
                    out_payload_next.median_valid = valid_reg;
                    out_valid_next                = 1'b1;
                    state_next                    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        // A window size write restarts the window and clears the tree.
        if (cfg_we)
        begin
            window_size_next = cfg_wdata;
            wp_next          = '0;
            fill_next        = '0;
            clr_next         = '0;
            state_next       = ST_CLEAR;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            window_size_reg <= swm_pkg::WINDOW_SIZE_RESET;
            wp_reg          <= '0;
            fill_reg        <= '0;
            best_reg        <= '0;
            clr_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            window_size_reg <= window_size_next;
            wp_reg          <= wp_next;
            fill_reg        <= fill_next;
            best_reg        <= best_next;
            clr_reg         <= clr_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Working registers of the request in flight.
    always_ff @(posedge clk)
    begin
        sample_reg      <= sample_next;
        k_reg           <= k_next;
        slot_reg        <= slot_next;
        remove_reg      <= remove_next;
        idx_reg         <= idx_next;
        pos_reg         <= pos_next;
        rem_reg         <= rem_next;
        step_reg        <= step_next;
        med_reg         <= med_next;
        valid_reg       <= valid_next;
        out_payload_reg <= out_payload_next;
    end

endmodule

>>> hw/rtl/swm_checker.sv
`include "sliding_window_median_max_unit_macros.svh"

// Port-level checks of the sliding window median unit.
module swm_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      cfg_we,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [swm_pkg::OUT_W-1:0] median,
    input logic                      median_valid,
    input logic [swm_pkg::OUT_W-1:0] running_max
);

    // A result waiting for its request to be taken stays offered.
    `SWM_ASSERT_NXT(a_result_held, out_valid && !out_ready, out_valid,
        "result withdrawn before it was taken")

    // Before the window is full the median reads as zero.
    `SWM_ASSERT_IMP(a_median_zero, out_valid && !median_valid, median == '0,
        "median not zero on an incomplete window")

    // The running maximum covers the median it is reported with.
    `SWM_ASSERT_IMP(a_max_bounds, out_valid && median_valid, running_max >= median,
        "running maximum below the current median")

    // Only one sample is worked on at a time.
    `SWM_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready,
        "sample taken while another is in progress")

    // A window size write starts a tree clear that blocks new samples.
    `SWM_ASSERT_NXT(a_restart_blocks, cfg_we, !in_ready,
        "sample taken during the tree clear")

endmodule

bind sliding_window_median_max_unit swm_checker u_swm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .in_valid     (samples.valid),
    .in_ready     (samples.ready),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .median       (results.payload.median),
    .median_valid (results.payload.median_valid),
    .running_max  (results.payload.running_max)
);

>>> tb/testbench.sv
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TREE_SIZE     = 1 << swm_pkg::SAMPLE_W;
    localparam int MAX_WINDOW    = 256;
    localparam int IDLE_PERCENT  = 14;
    localparam int TAIL_CYCLES   = 40;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DIRECTED_ROWS = 23;
    localparam int PHASES        = 9;

    typedef enum logic {ROW_SAMPLE, ROW_CONFIG} row_kind_t;

    // One line of the directed table: a sample request or a window write.
    typedef struct {
        row_kind_t             kind;
        logic [9:0]            value;
        bit                    typed;
        swm_pkg::result_item_t want;
    } stim_row_t;

    // One random phase: window setting, request count, sample ceiling and calm flag.
    typedef struct {
        int unsigned window;
        bit          any_window;
        int unsigned items;
        int unsigned cap;
        bit          calm;
    } phase_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    logic [swm_pkg::WIN_W-1:0]    cfg_wdata;

    swm_stream_if #(.payload_t(swm_pkg::sample_item_t)) sample_ch ();
    swm_stream_if #(.payload_t(swm_pkg::result_item_t)) result_ch ();

    sliding_window_median_max_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .samples   (sample_ch),
        .results   (result_ch)
    );

    // Shadow copy of the block's window state.
    logic [swm_pkg::WIN_W-1:0]    window_reg;
    int                           tally [1:TREE_SIZE];
    logic [swm_pkg::SAMPLE_W-1:0] ring [MAX_WINDOW];
    int unsigned                  ring_ptr;
    int unsigned                  fill_level;
    logic [swm_pkg::OUT_W-1:0]    best_median_seen;
    logic [swm_pkg::SAMPLE_W-1:0] last_sample;

    swm_pkg::result_item_t        pending_results [$];
    bit                           calm;
    int unsigned                  items_sent;
    int unsigned                  results_checked;
    int unsigned                  window_writes;
    int unsigned                  mismatch_count;
    int unsigned                  cycle_count;

    // The directed table. Expected values are typed in where they are obvious.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_SAMPLE, 10'd1023, 1'b1, '{10'd0,  1'b0, 10'd0}},
        '{ROW_SAMPLE, 10'd0,    1'b1, '{10'd0,  1'b0, 10'd0}},
        '{ROW_SAMPLE, 10'd0,    1'b1, '{10'd0,  1'b1, 10'd0}},
        '{ROW_SAMPLE, 10'd40,   1'b0, '{10'd0,  1'b0, 10'd0}},
        '{ROW_SAMPLE, 10'd40,   1'b0, '{10'd0,  1'b0, 10'd0}},
        '{ROW_CONFIG, 10'd1,    1'b0, '{10'd0,  1'b0, 10'd0}},
        '{ROW_SAMPLE, 10'd0,    1'b1, '{10'd0,  1'b1, 10'd40}},
        '{ROW_SAMPLE, 10'd25,   1'b1, '{10'd25, 1'b1, 10'd40}},
        '{ROW_SAMPLE, 10'd60,   1'b0, '{10'd0,  1'b0, 10'd0}},
        '{ROW_CONFIG, 10'd0,    1'b0, '{10'd0,  1'b0, 10'd0}},
        '{ROW_SAMPLE, 10'd50,   1'b1, '{10'd50, 1'b1, 10'd60}},
        '{ROW_SAMPLE, 10'd3,    1'b0, '{10'd0,  1'b0, 10'd0}},
        '{ROW_CONFIG, 10'd2,    1'b0, '{10'd0,  1'b0, 10'd0}},
        '{ROW_SAMPLE, 10'd1023, 1'b1, '{10'd0,  1'b0, 10'd60}},
        '{ROW_SAMPLE, 10'd0,    1'b1, '{10'd0,  1'b1, 10'd60}},
        '{ROW_SAMPLE, 10'd70,   1'b0, '{10'd0,  1'b0, 10'd0}},
        '{ROW_SAMPLE, 10'd70,   1'b0, '{10'd0,  1'b0, 10'd0}},
        '{ROW_CONFIG, 10'd4,    1'b0, '{10'd0,  1'b0, 10'd0}},
        '{ROW_SAMPLE, 10'd9,    1'b0, '{10'd0,  1'b0, 10'd0}},
        '{ROW_SAMPLE, 10'd9,    1'b0, '{10'd0,  1'b0, 10'd0}},
        '{ROW_SAMPLE, 10'd1,    1'b0, '{10'd0,  1'b0, 10'd0}},
        '{ROW_SAMPLE, 10'd1023, 1'b0, '{10'd0,  1'b0, 10'd0}},
        '{ROW_SAMPLE, 10'd80,   1'b0, '{10'd0,  1'b0, 10'd0}}
    };

    // Random phases. The sample ceiling rises so that the running maximum
    // climbs slowly rather than saturating early.
    phase_t phases [PHASES] = '{
        '{7,   1'b0, 80,  200,  1'b0},
        '{256, 1'b0, 290, 300,  1'b0},
        '{33,  1'b0, 90,  450,  1'b1},
        '{511, 1'b0, 280, 600,  1'b0},
        '{2,   1'b0, 60,  700,  1'b0},
        '{0,   1'b1, 80,  800,  1'b0},
        '{3,   1'b0, 80,  1023, 1'b0},
        '{1,   1'b0, 40,  1023, 1'b0},
        '{0,   1'b0, 30,  1023, 1'b0}
    };

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Reset is asserted at the start of the run only.
    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Clearing a window empties the count tree and the fill state.
    function automatic void restart_window_model();
        for (int i = 1; i <= TREE_SIZE; i++)
        begin
            tally[i] = 0;
        end
        ring_ptr   = 0;
        fill_level = 0;
    endfunction

    // Fenwick update at value v, tree index v + 1.
    function automatic void tally_add(input logic [swm_pkg::SAMPLE_W-1:0] v,
                                      input int delta);
        int unsigned idx;
        idx = int'(v) + 1;
        while (idx <= TREE_SIZE)
        begin
            tally[idx] = tally[idx] + delta;
            idx = idx + (idx & (~idx + 1));
        end
    endfunction

    // Smallest value whose inclusive count exceeds the given rank.
    function automatic logic [swm_pkg::SAMPLE_W-1:0] find_rank(input int unsigned rank);
        int unsigned pos;
        int unsigned rem;
        int unsigned step;
        int unsigned nxt;
        pos  = 0;
        rem  = rank;
        step = TREE_SIZE;
        while (step != 0)
        begin
            nxt = pos + step;
            if (nxt <= TREE_SIZE && tally[nxt] <= int'(rem))
            begin
                pos = nxt;
                rem = rem - tally[nxt];
            end
            step = step >> 1;
        end
        if (pos >= TREE_SIZE)
        begin
            pos = TREE_SIZE - 1;
        end
        return pos[swm_pkg::SAMPLE_W-1:0];
    endfunction

    // Advances the shadow window by one sample and returns the median result.
    function automatic swm_pkg::result_item_t predict_window(
        input logic [swm_pkg::SAMPLE_W-1:0] s);
        int unsigned           k;
        int unsigned           wp;
        swm_pkg::result_item_t r;
        if (window_reg == 0)
        begin
            k = 1;
        end
        else if (window_reg > MAX_WINDOW)
        begin
            k = MAX_WINDOW;
        end
        else
        begin
            k = window_reg;
        end
        wp = ring_ptr;
        if (wp >= k)
        begin
            wp = 0;
        end
        if (fill_level >= k)
        begin
            tally_add(ring[wp], -1);
            fill_level = k - 1;
        end
        ring[wp] = s;
        tally_add(s, 1);
        fill_level++;
        wp++;
        if (wp >= k)
        begin
            wp = 0;
        end
        ring_ptr = wp;

        r = '0;
        if (fill_level >= k)
        begin
            r.median_valid = 1'b1;
            r.median       = find_rank((k - 1) / 2);
            if (r.median > best_median_seen)
            begin
                best_median_seen = r.median;
            end
        end
        r.running_max = best_median_seen;
        return r;
    endfunction

    // Random sample with a mix of spread, clustered, extreme and repeated values.
    function automatic logic [swm_pkg::SAMPLE_W-1:0] pick_sample(input int unsigned cap);
        int unsigned roll;
        int unsigned v;
        roll = $urandom_range(99);
        if (roll < 45)
        begin
            v = $urandom_range(cap, 0);
        end
        else if (roll < 70)
        begin
            v = $urandom_range(cap, 0) + $urandom_range(3);
            if (v > cap)
            begin
                v = cap;
            end
        end
        else if (roll < 85)
        begin
            case ($urandom_range(2))
                0:       v = 0;
                1:       v = cap;
                default: v = TREE_SIZE - 1;
            endcase
        end
        else
        begin
            v = last_sample;
        end
        last_sample = v[swm_pkg::SAMPLE_W-1:0];
        return v[swm_pkg::SAMPLE_W-1:0];
    endfunction

    // Offers one sample request, called and returning at a falling edge.
    task automatic send_sample(input logic [swm_pkg::SAMPLE_W-1:0] s, input bit typed,
                               input swm_pkg::result_item_t want);
        swm_pkg::result_item_t predicted;
        while (!calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid          <= 1'b1;
        sample_ch.payload.sample <= s;
        do
        begin
            @(posedge clk);
        end
        while (!sample_ch.ready);
        predicted = predict_window(s);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
        items_sent++;
        @(negedge clk);
    endtask

    // Writes the window size once every outstanding result has arrived.
    task automatic write_window(input logic [swm_pkg::WIN_W-1:0] value);
        sample_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
        cfg_we     <= 1'b1;
        cfg_wdata  <= value;
        window_reg  = value;
        restart_window_model();
        window_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Main stimulus: the directed table, then the random phases.
    initial
    begin
        logic [swm_pkg::WIN_W-1:0] win;
        cfg_we                   <= 1'b0;
        cfg_wdata                <= '0;
        sample_ch.valid          <= 1'b0;
        sample_ch.payload        <= '0;
        calm                      = 1'b0;
        items_sent                = 0;
        window_writes             = 0;
        last_sample               = '0;
        best_median_seen          = '0;
        window_reg                = swm_pkg::WINDOW_SIZE_RESET;
        restart_window_model();

        @(posedge rst_n);
        @(negedge clk);

        for (int row = 0; row < DIRECTED_ROWS; row++)
        begin
            if (directed_rows[row].kind == ROW_CONFIG)
            begin
                write_window(directed_rows[row].value[swm_pkg::WIN_W-1:0]);
            end
            else
            begin
                send_sample(directed_rows[row].value, directed_rows[row].typed,
                            directed_rows[row].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            win = phases[ph].any_window ? swm_pkg::WIN_W'($urandom_range(40, 1))
                                        : swm_pkg::WIN_W'(phases[ph].window);
            write_window(win);
            calm = phases[ph].calm;
            repeat (phases[ph].items)
            begin
                send_sample(pick_sample(phases[ph].cap), 1'b0, '0);
            end
            calm = 1'b0;
        end

        // Drain the outstanding results and allow for any stray output.
        sample_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d sample requests under %0d window writes (sizes 0 to 511).",
                 items_sent, window_writes);
        $display("Checked %0d results with random stalls on both channels.",
                 results_checked);
        if (mismatch_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // The result side stalls at random except during calm stretches.
    initial
    begin
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            result_ch.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        swm_pkg::result_item_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result with none expected: expected none actual %p",
                         $time, result_ch.payload);
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (result_ch.payload.median !== want.median)
                begin
                    mismatch_count++;
                    $display("%0t: median expected %0d actual %0d", $time,
                             want.median, result_ch.payload.median);
                end
                if (result_ch.payload.median_valid !== want.median_valid)
                begin
                    mismatch_count++;
                    $display("%0t: median_valid expected %0b actual %0b", $time,
                             want.median_valid, result_ch.payload.median_valid);
                end
                if (result_ch.payload.running_max !== want.running_max)
                begin
                    mismatch_count++;
                    $display("%0t: running_max expected %0d actual %0d", $time,
                             want.running_max, result_ch.payload.running_max);
                end
            end
        end
    end

    // Cycle counter guarding against a hung handshake.
    initial
    begin
        mismatch_count  = 0;
        results_checked = 0;
        cycle_count     = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("%0t: cycle limit reached with %0d results outstanding",
                         $time, pending_results.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

endmodule
